@@ hw/rtl/tble_pkg.sv @@
// Types and constants shared by the line editor and its checker.
package tble_pkg;

  localparam int COLUMNS = 32;
  localparam int LINES   = 32;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(LINES);
  localparam int CNT_W   = $clog2(LINES + 1);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int CH_W    = 7;

  localparam logic [CH_W-1:0]  PRINT_LO = CH_W'(32);
  localparam logic [CH_W-1:0]  PRINT_HI = CH_W'(126);
  localparam logic [COL_W-1:0] MAX_LEN  = COL_W'(COLUMNS - 1);
  localparam logic [CNT_W-1:0] MAX_ROWS = CNT_W'(LINES);

  localparam logic [3:0] CMD_INSERT = 4'd0;
  localparam logic [3:0] CMD_BKSP   = 4'd1;
  localparam logic [3:0] CMD_ENTER  = 4'd2;
  localparam logic [3:0] CMD_DELETE = 4'd3;
  localparam logic [3:0] CMD_LEFT   = 4'd4;
  localparam logic [3:0] CMD_RIGHT  = 4'd5;
  localparam logic [3:0] CMD_UP     = 4'd6;
  localparam logic [3:0] CMD_DOWN   = 4'd7;
  localparam logic [3:0] CMD_HOME   = 4'd8;
  localparam logic [3:0] CMD_END    = 4'd9;
  localparam logic [3:0] CMD_PGUP   = 4'd10;
  localparam logic [3:0] CMD_PGDN   = 4'd11;
  localparam logic [3:0] CMD_FINISH = 4'd12;
  localparam logic [3:0] CMD_READ   = 4'd13;

  typedef struct packed {
    logic [3:0]       command;
    logic [CH_W-1:0]  character;
    logic [4:0]       read_row;
    logic [4:0]       read_column;
  } in_t;

  typedef struct packed {
    logic [4:0]       cursor_column;
    logic [4:0]       cursor_row;
    logic [5:0]       rows_in_use;
    logic             finished;
    logic [CH_W-1:0]  read_character;
    logic [4:0]       read_row_length;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CUR, ST_COPY, ST_INS_END, ST_DEL_END,
    ST_JOIN_A, ST_JOIN_B, ST_JOIN_C, ST_JOIN_D,
    ST_ROW_CHK, ST_ROW_GOT, ST_ROW_WL, ST_JOIN_END,
    ST_ENT_SPLIT, ST_ENT_FIN, ST_ENT_FIN2, ST_MOVE, ST_RESULT
  } state_t;

endpackage

@@ hw/rtl/text_buffer_line_editor_top.sv @@
// Line editor: text store and row lengths in synchronous RAMs, driven by a sequencer.
// Read, finish and most cursor moves are settled in ST_CUR; moves that need another row's
// length go through ST_MOVE; edits copy one character a cycle, and row shifts copy each moved row in turn.
// One request at a time: the next is taken only once the result has been issued.
// Reset: cursor 0,0, one row in use, all row lengths read as 0 at once; text RAM not cleared.
module text_buffer_line_editor_top import tble_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [CH_W-1:0]  tm_mem [COLUMNS*LINES];
  logic [COL_W-1:0] lm_mem [LINES];
  logic [LINES-1:0] lv_r;

  logic [CH_W-1:0]   tm_q_r;
  logic [COL_W-1:0]  lm_q_r;
  logic              lmv_r;
  logic [COL_W-1:0]  lq;

  logic              tm_we;
  logic [ADDR_W-1:0] tm_waddr, tm_raddr;
  logic [CH_W-1:0]   tm_wdata;
  logic              lm_we;
  logic [ROW_W-1:0]  lm_waddr, lm_raddr;
  logic [COL_W-1:0]  lm_wdata;

  state_t st_r, st_nxt, ret_r, ret_nxt;
  logic [3:0]       cmd_r, cmd_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [4:0]       rc_r, rc_nxt;
  logic [COL_W-1:0] cx_r, cx_nxt, len_r, len_nxt, dlen_r, dlen_nxt, rl_r, rl_nxt;
  logic [ROW_W-1:0] cy_r, cy_nxt, tgt_r, tgt_nxt, jd_r, jd_nxt, ri_r, ri_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt, clamp_r, clamp_nxt, up_r, up_nxt;
  logic [CH_W-1:0]  rchar_r, rchar_nxt;
  logic [COL_W-1:0] rlen_r, rlen_nxt;
  out_t             out_r, out_nxt;
  logic             ov_r, ov_nxt;

  logic [ROW_W-1:0] cs_row_r, cs_row_nxt, cd_row_r, cd_row_nxt;
  logic [COL_W-1:0] cs_col_r, cs_col_nxt, cd_col_r, cd_col_nxt, cl_r, cl_nxt;
  logic             desc_r, desc_nxt, wp_r, wp_nxt;

  logic [COL_W-1:0] cxc, room, njoin;
  logic [ROW_W-1:0] rsrc, rdst;
  logic [CNT_W-1:0] cy1, ri1;

  assign lq        = lmv_r ? lm_q_r : '0;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign cxc       = (cx_r > lq) ? lq : cx_r;
  assign room      = MAX_LEN - dlen_r;
  assign njoin     = (lq < room) ? lq : room;
  assign cy1       = {1'b0, cy_r} + CNT_W'(1);
  assign ri1       = {1'b0, ri_r} + CNT_W'(1);
  assign rsrc      = up_r ? ri_r + ROW_W'(1) : ri_r - ROW_W'(1);
  assign rdst      = ri_r;

  always_ff @(posedge clk) begin
    if (tm_we) tm_mem[tm_waddr] <= tm_wdata;
    tm_q_r <= tm_mem[tm_raddr];
  end

  always_ff @(posedge clk) begin
    if (lm_we) lm_mem[lm_waddr] <= lm_wdata;
    lm_q_r <= lm_mem[lm_raddr];
    lmv_r  <= lv_r[lm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else if (lm_we) begin
      lv_r[lm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cx_r   <= '0;
      cy_r   <= '0;
      cnt_r  <= CNT_W'(1);
      done_r <= 1'b0;
      ov_r   <= 1'b0;
      wp_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      ov_r   <= ov_nxt;
      wp_r   <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;
    cmd_r    <= cmd_nxt;
    ch_r     <= ch_nxt;
    rc_r     <= rc_nxt;
    len_r    <= len_nxt;
    dlen_r   <= dlen_nxt;
    rl_r     <= rl_nxt;
    tgt_r    <= tgt_nxt;
    jd_r     <= jd_nxt;
    ri_r     <= ri_nxt;
    clamp_r  <= clamp_nxt;
    up_r     <= up_nxt;
    rchar_r  <= rchar_nxt;
    rlen_r   <= rlen_nxt;
    out_r    <= out_nxt;
    cs_row_r <= cs_row_nxt;
    cs_col_r <= cs_col_nxt;
    cd_row_r <= cd_row_nxt;
    cd_col_r <= cd_col_nxt;
    cl_r     <= cl_nxt;
    desc_r   <= desc_nxt;
  end

  always_comb begin
    st_nxt = st_r;     ret_nxt = ret_r;   cmd_nxt = cmd_r;   ch_nxt = ch_r;
    rc_nxt = rc_r;     cx_nxt = cx_r;     cy_nxt = cy_r;     cnt_nxt = cnt_r;
    done_nxt = done_r; len_nxt = len_r;   dlen_nxt = dlen_r; rl_nxt = rl_r;
    tgt_nxt = tgt_r;   jd_nxt = jd_r;     ri_nxt = ri_r;     clamp_nxt = clamp_r;
    up_nxt = up_r;     rchar_nxt = rchar_r; rlen_nxt = rlen_r; out_nxt = out_r;
    ov_nxt = ov_r && !out_ready;
    cs_row_nxt = cs_row_r; cs_col_nxt = cs_col_r;
    cd_row_nxt = cd_row_r; cd_col_nxt = cd_col_r;
    cl_nxt = cl_r; desc_nxt = desc_r; wp_nxt = 1'b0;
    tm_we = 1'b0; tm_waddr = '0; tm_wdata = '0; tm_raddr = '0;
    lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0; lm_raddr = '0;

    unique case (st_r)
      ST_IDLE: begin
        lm_raddr = (in_data.command == CMD_READ) ? in_data.read_row : cy_r;
        tm_raddr = {in_data.read_row, in_data.read_column};
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          ch_nxt    = in_data.character;
          rc_nxt    = in_data.read_column;
          rchar_nxt = '0;
          rlen_nxt  = '0;
          st_nxt    = ST_CUR;
        end
      end
      ST_CUR: begin
        st_nxt = ST_RESULT;
        if (cmd_r == CMD_READ) begin
          rlen_nxt  = lq;
          rchar_nxt = (rc_r < lq) ? tm_q_r : '0;
        end else if (cmd_r == CMD_FINISH) begin
          done_nxt = 1'b1;
        end else if (cmd_r <= CMD_PGDN && !done_r) begin
          len_nxt = lq;
          cx_nxt  = cxc;
          unique case (cmd_r)
            CMD_INSERT: begin
              if (ch_r >= PRINT_LO && ch_r <= PRINT_HI && lq < MAX_LEN) begin
                cs_row_nxt = cy_r; cs_col_nxt = lq - COL_W'(1);
                cd_row_nxt = cy_r; cd_col_nxt = lq;
                cl_nxt = lq - cxc; desc_nxt = 1'b1;
                ret_nxt = ST_INS_END; st_nxt = ST_COPY;
              end
            end
            CMD_BKSP: begin
              if (cxc != '0) begin
                cx_nxt = cxc - COL_W'(1);
                cs_row_nxt = cy_r; cs_col_nxt = cxc;
                cd_row_nxt = cy_r; cd_col_nxt = cxc - COL_W'(1);
                cl_nxt = lq - cxc; desc_nxt = 1'b0;
                ret_nxt = ST_DEL_END; st_nxt = ST_COPY;
              end else if (cy_r != '0) begin
                jd_nxt = cy_r - ROW_W'(1);
                cy_nxt = cy_r - ROW_W'(1);
                st_nxt = ST_JOIN_A;
              end
            end
            CMD_ENTER: begin
              if (cnt_r < MAX_ROWS) begin
                ri_nxt = cnt_r[ROW_W-1:0];
                up_nxt = 1'b0;
                st_nxt = ST_ROW_CHK;
              end
            end
            CMD_DELETE: begin
              if (cxc < lq) begin
                cs_row_nxt = cy_r; cs_col_nxt = cxc + COL_W'(1);
                cd_row_nxt = cy_r; cd_col_nxt = cxc;
                cl_nxt = lq - cxc - COL_W'(1); desc_nxt = 1'b0;
                ret_nxt = ST_DEL_END; st_nxt = ST_COPY;
              end else if (cy1 < cnt_r) begin
                jd_nxt = cy_r;
                st_nxt = ST_JOIN_A;
              end
            end
            CMD_LEFT: begin
              if (cxc != '0) begin
                cx_nxt = cxc - COL_W'(1);
              end else if (cy_r != '0) begin
                lm_raddr = cy_r - ROW_W'(1);
                tgt_nxt = cy_r - ROW_W'(1); clamp_nxt = 1'b0; st_nxt = ST_MOVE;
              end
            end
            CMD_RIGHT: begin
              if (cxc < lq) begin
                cx_nxt = cxc + COL_W'(1);
              end else if (cy1 < cnt_r) begin
                cy_nxt = cy_r + ROW_W'(1);
                cx_nxt = '0;
              end
            end
            CMD_UP: begin
              if (cy_r != '0) begin
                lm_raddr = cy_r - ROW_W'(1);
                tgt_nxt = cy_r - ROW_W'(1); clamp_nxt = 1'b1; st_nxt = ST_MOVE;
              end
            end
            CMD_DOWN: begin
              if (cy1 < cnt_r) begin
                lm_raddr = cy_r + ROW_W'(1);
                tgt_nxt = cy_r + ROW_W'(1); clamp_nxt = 1'b1; st_nxt = ST_MOVE;
              end
            end
            CMD_HOME: cx_nxt = '0;
            CMD_END:  cx_nxt = lq;
            CMD_PGUP: begin
              cx_nxt = '0;
              cy_nxt = '0;
            end
            CMD_PGDN: begin
              lm_raddr = ROW_W'(cnt_r - CNT_W'(1));
              tgt_nxt = ROW_W'(cnt_r - CNT_W'(1)); clamp_nxt = 1'b0; st_nxt = ST_MOVE;
            end
            default: ;
          endcase
        end
      end
      ST_COPY: begin
        if (cl_r != '0) begin
          tm_raddr   = {cs_row_r, cs_col_r};
          cs_col_nxt = desc_r ? cs_col_r - COL_W'(1) : cs_col_r + COL_W'(1);
          cl_nxt     = cl_r - COL_W'(1);
          wp_nxt     = 1'b1;
        end else begin
          st_nxt = ret_r;
        end
        if (wp_r) begin
          tm_we      = 1'b1;
          tm_waddr   = {cd_row_r, cd_col_r};
          tm_wdata   = tm_q_r;
          cd_col_nxt = desc_r ? cd_col_r - COL_W'(1) : cd_col_r + COL_W'(1);
        end
      end
      ST_INS_END: begin
        tm_we = 1'b1; tm_waddr = {cy_r, cx_r}; tm_wdata = ch_r;
        lm_we = 1'b1; lm_waddr = cy_r; lm_wdata = len_r + COL_W'(1);
        cx_nxt = cx_r + COL_W'(1);
        st_nxt = ST_RESULT;
      end
      ST_DEL_END: begin
        lm_we = 1'b1; lm_waddr = cy_r; lm_wdata = len_r - COL_W'(1);
        st_nxt = ST_RESULT;
      end
      ST_JOIN_A: begin
        lm_raddr = jd_r;
        st_nxt = ST_JOIN_B;
      end
      ST_JOIN_B: begin
        dlen_nxt = lq;
        lm_raddr = jd_r + ROW_W'(1);
        st_nxt = ST_JOIN_C;
      end
      ST_JOIN_C: begin
        cx_nxt  = dlen_r;
        len_nxt = njoin;
        cs_row_nxt = jd_r + ROW_W'(1); cs_col_nxt = '0;
        cd_row_nxt = jd_r; cd_col_nxt = dlen_r;
        cl_nxt = njoin; desc_nxt = 1'b0;
        ret_nxt = ST_JOIN_D; st_nxt = ST_COPY;
      end
      ST_JOIN_D: begin
        lm_we = 1'b1; lm_waddr = jd_r; lm_wdata = dlen_r + len_r;
        ri_nxt = jd_r + ROW_W'(1);
        up_nxt = 1'b1;
        st_nxt = ST_ROW_CHK;
      end
      ST_ROW_CHK: begin
        lm_raddr = rsrc;
        if (up_r ? (ri1 < cnt_r) : ({1'b0, ri_r} > cy1)) begin
          st_nxt = ST_ROW_GOT;
        end else begin
          st_nxt = up_r ? ST_JOIN_END : ST_ENT_SPLIT;
        end
      end
      ST_ROW_GOT: begin
        rl_nxt = lq;
        cs_row_nxt = rsrc; cs_col_nxt = '0;
        cd_row_nxt = rdst; cd_col_nxt = '0;
        cl_nxt = lq; desc_nxt = 1'b0;
        ret_nxt = ST_ROW_WL; st_nxt = ST_COPY;
      end
      ST_ROW_WL: begin
        lm_we = 1'b1; lm_waddr = rdst; lm_wdata = rl_r;
        ri_nxt = up_r ? ri_r + ROW_W'(1) : ri_r - ROW_W'(1);
        st_nxt = ST_ROW_CHK;
      end
      ST_JOIN_END: begin
        lm_we = 1'b1; lm_waddr = ROW_W'(cnt_r - CNT_W'(1)); lm_wdata = '0;
        cnt_nxt = cnt_r - CNT_W'(1);
        st_nxt = ST_RESULT;
      end
      ST_ENT_SPLIT: begin
        cs_row_nxt = cy_r; cs_col_nxt = cx_r;
        cd_row_nxt = cy_r + ROW_W'(1); cd_col_nxt = '0;
        cl_nxt = len_r - cx_r; desc_nxt = 1'b0;
        ret_nxt = ST_ENT_FIN; st_nxt = ST_COPY;
      end
      ST_ENT_FIN: begin
        lm_we = 1'b1; lm_waddr = cy_r + ROW_W'(1); lm_wdata = len_r - cx_r;
        st_nxt = ST_ENT_FIN2;
      end
      ST_ENT_FIN2: begin
        lm_we = 1'b1; lm_waddr = cy_r; lm_wdata = cx_r;
        cnt_nxt = cnt_r + CNT_W'(1);
        cy_nxt  = cy_r + ROW_W'(1);
        cx_nxt  = '0;
        st_nxt  = ST_RESULT;
      end
      ST_MOVE: begin
        cy_nxt = tgt_r;
        cx_nxt = (clamp_r && cx_r <= lq) ? cx_r : lq;
        st_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          out_nxt.cursor_column   = cx_r;
          out_nxt.cursor_row      = cy_r;
          out_nxt.rows_in_use     = cnt_r;
          out_nxt.finished        = done_r;
          out_nxt.read_character  = rchar_r;
          out_nxt.read_row_length = rlen_r;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/tble_chk.sv @@
// Port checker for the line editor, bound to the top level.
module tble_chk import tble_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.rows_in_use != '0 && out_data.rows_in_use <= MAX_ROWS &&
      {1'b0, out_data.cursor_row} < out_data.rows_in_use)
    else $error("row count or cursor row out of range");

  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.finished ##1 out_valid |-> out_data.finished)
    else $error("finished flag cleared");

  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_character != '0 |->
      out_data.read_character >= PRINT_LO && out_data.read_character <= PRINT_HI)
    else $error("non-printable character read");

endmodule

bind text_buffer_line_editor_top tble_chk u_tble_chk (.*);

@@ dv/tble_checker.sv @@
// Checker for the line editor: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps
module tble_checker import tble_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  output int          errors,
  output int          pending
);
  logic [CH_W-1:0] text [LINES][COLUMNS];
  int              row_len [LINES];
  int              cur_col, cur_row, row_cnt;
  bit              done;
  out_t            expected_q [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic void shift_row(int dst, int src);
    text[dst] = text[src];
    row_len[dst] = row_len[src];
  endfunction

  function automatic void merge_rows(int dst);
    int src, dlen, slen, n, i, r;
    src = dst + 1;
    dlen = row_len[dst];
    slen = row_len[src];
    n = (slen < COLUMNS - 1 - dlen) ? slen : COLUMNS - 1 - dlen;
    for (i = 0; i < n; i++) text[dst][dlen + i] = text[src][i];
    row_len[dst] = dlen + n;
    for (r = src; r + 1 < row_cnt; r++) shift_row(r, r + 1);
    row_len[row_cnt - 1] = 0;
    row_cnt--;
  endfunction

  function automatic void apply_edit(logic [3:0] cmd, int ch);
    int cy, cx, len, i, right;
    cy = cur_row;
    cx = cur_col;
    len = row_len[cy];
    if (cx > len) cx = len;
    case (cmd)
      CMD_INSERT: if (ch >= PRINT_LO && ch <= PRINT_HI && len < COLUMNS - 1) begin
        for (i = len; i > cx; i--) text[cy][i] = text[cy][i - 1];
        text[cy][cx] = CH_W'(ch);
        row_len[cy] = len + 1;
        cx++;
      end
      CMD_BKSP: if (cx > 0) begin
        cx--;
        for (i = cx; i + 1 < len; i++) text[cy][i] = text[cy][i + 1];
        row_len[cy] = len - 1;
      end else if (cy > 0) begin
        cx = row_len[cy - 1];
        merge_rows(cy - 1);
        cy--;
      end
      CMD_ENTER: if (row_cnt < LINES) begin
        right = len - cx;
        for (i = row_cnt; i > cy + 1; i--) shift_row(i, i - 1);
        for (i = 0; i < right; i++) text[cy + 1][i] = text[cy][cx + i];
        row_len[cy + 1] = right;
        row_len[cy] = cx;
        row_cnt++;
        cy++;
        cx = 0;
      end
      CMD_DELETE: if (cx < len) begin
        for (i = cx; i + 1 < len; i++) text[cy][i] = text[cy][i + 1];
        row_len[cy] = len - 1;
      end else if (cy + 1 < row_cnt) begin
        merge_rows(cy);
      end
      CMD_LEFT: if (cx > 0) cx--;
                else if (cy > 0) begin cy--; cx = row_len[cy]; end
      CMD_RIGHT: if (cx < len) cx++;
                 else if (cy + 1 < row_cnt) begin cy++; cx = 0; end
      CMD_UP: if (cy > 0) begin
        cy--;
        if (cx > row_len[cy]) cx = row_len[cy];
      end
      CMD_DOWN: if (cy + 1 < row_cnt) begin
        cy++;
        if (cx > row_len[cy]) cx = row_len[cy];
      end
      CMD_HOME: cx = 0;
      CMD_END:  cx = len;
      CMD_PGUP: begin cx = 0; cy = 0; end
      CMD_PGDN: begin cy = row_cnt - 1; cx = row_len[cy]; end
      default: ;
    endcase
    cur_row = cy;
    cur_col = cx;
  endfunction

  function automatic out_t predict_result(in_t req);
    out_t res;
    res = '0;
    if (req.command <= CMD_PGDN) begin
      if (!done) apply_edit(req.command, int'(req.character));
    end else if (req.command == CMD_FINISH) begin
      done = 1;
    end else if (req.command == CMD_READ) begin
      if (req.read_row < LINES) begin
        res.read_row_length = 5'(row_len[req.read_row]);
        if (req.read_column < row_len[req.read_row])
          res.read_character = text[req.read_row][req.read_column];
      end
    end
    res.cursor_column = 5'(cur_col);
    res.cursor_row = 5'(cur_row);
    res.rows_in_use = 6'(row_cnt);
    res.finished = done;
    return res;
  endfunction

  always @(posedge clk) begin
    out_t exp_res;
    if (!rst_n) begin
      foreach (row_len[i]) row_len[i] = 0;
      cur_col = 0;
      cur_row = 0;
      row_cnt = 1;
      done = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (exp_res !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_res, out_data);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_result(in_data));
    end
    pending = expected_q.size();
  end
endmodule

@@ dv/testbench.sv @@
// Testbench top: drives key requests into the line editor and gives the verdict.
`timescale 1ns / 1ps
module testbench;
  import tble_pkg::*;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  int   errors, pending, cycles, stall;
  bit   quiet;

  text_buffer_line_editor_top dut (.*);
  tble_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
      stall = 0;
    end else if (stall > 0) begin
      stall--;
      out_ready <= (stall == 0);
    end else if ($urandom_range(0, 3) == 0) begin
      stall = $urandom_range(1, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_key(logic [3:0] cmd, int ch, int rr, int rc);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_data <= '{cmd, ch[6:0], rr[4:0], rc[4:0]};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_key();
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) send_key(CMD_INSERT, $urandom_range(32, 126), $urandom, $urandom);
    else if (p < 33) send_key(CMD_INSERT, $urandom_range(0, 127), $urandom, $urandom);
    else if (p < 42) send_key(CMD_ENTER, $urandom, $urandom, $urandom);
    else if (p < 50) send_key(CMD_BKSP, 0, $urandom, $urandom);
    else if (p < 57) send_key(CMD_DELETE, 0, $urandom, $urandom);
    else if (p < 80) send_key(4'($urandom_range(CMD_LEFT, CMD_PGDN)), $urandom, $urandom,
                              $urandom);
    else if (p < 98) send_key(CMD_READ, $urandom, $urandom_range(0, 31), $urandom_range(0, 31));
    else send_key(4'($urandom_range(14, 15)), $urandom, $urandom, $urandom);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 1;
    quiet = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: edges of the store and the special cases
    send_key(CMD_BKSP, 0, 0, 0);
    send_key(CMD_DELETE, 0, 0, 0);
    send_key(CMD_LEFT, 0, 0, 0);
    send_key(CMD_RIGHT, 0, 0, 0);
    send_key(CMD_INSERT, 31, 0, 0);
    send_key(CMD_INSERT, 127, 0, 0);
    send_key(CMD_INSERT, 126, 0, 0);
    send_key(CMD_INSERT, 32, 0, 0);
    repeat (31) send_key(CMD_INSERT, $urandom_range(33, 125), 0, 0);
    send_key(CMD_READ, 0, 0, 30);
    send_key(CMD_READ, 0, 31, 31);
    send_key(CMD_HOME, 0, 0, 0);
    send_key(CMD_ENTER, 0, 0, 0);
    send_key(CMD_BKSP, 0, 0, 0);
    send_key(CMD_END, 0, 0, 0);
    send_key(CMD_ENTER, 0, 0, 0);
    send_key(CMD_INSERT, 65, 0, 0);
    send_key(CMD_LEFT, 0, 0, 0);
    send_key(CMD_LEFT, 0, 0, 0);
    send_key(CMD_RIGHT, 0, 0, 0);
    send_key(CMD_DELETE, 0, 0, 0);
    send_key(CMD_UP, 0, 0, 0);
    send_key(CMD_DOWN, 0, 0, 0);
    send_key(CMD_PGDN, 0, 0, 0);
    send_key(CMD_PGUP, 0, 0, 0);
    repeat (35) send_key(CMD_ENTER, 0, 0, 0);
    send_key(CMD_READ, 0, 31, 0);
    send_key(CMD_PGDN, 0, 0, 0);
    repeat (20) send_key(CMD_BKSP, 0, 0, 0);
    for (int i = 0; i < 390; i++) begin
      if (i == 340) quiet = 1;
      random_key();
    end
    send_key(CMD_FINISH, 0, 0, 0);
    send_key(CMD_INSERT, 65, 0, 0);
    send_key(CMD_ENTER, 0, 0, 0);
    send_key(CMD_FINISH, 0, 0, 0);
    for (int r = 0; r < 32; r++) send_key(CMD_READ, 0, r, $urandom_range(0, 31));
    send_key(4'd15, 0, 0, 0);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/tble_pkg.sv
hw/rtl/text_buffer_line_editor_top.sv
hw/rtl/tble_chk.sv
dv/tble_checker.sv
dv/testbench.sv
